[hw/rtl/met_pkg.sv]
package met_pkg;

  // Field widths
  localparam int unsigned PixW     = 12;             // pixel column / row
  localparam int unsigned SizeW    = 13;             // frame width / height
  localparam int unsigned IterW    = 8;              // iteration count and limit
  localparam int unsigned IterMax  = 2**IterW - 1;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 13;

  // Fixed point: Q4.28 operands, exact Q8.56 products
  localparam int unsigned QW    = 32;
  localparam int unsigned FracW = 28;
  localparam int unsigned ProdW = 2 * QW;
  localparam int unsigned SumW  = ProdW - FracW + 2;  // shifted product plus c, with headroom

  // Coordinate divider: |scale * offset| in MagW bits, FracW fraction bits appended
  localparam int unsigned MagW    = PixW + 2;
  localparam int unsigned DivW    = MagW + FracW;
  localparam int unsigned DivCntW = $clog2(DivW);

  localparam int unsigned MaxIterLimitDef = 255;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgFrameWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgFrameHeight = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgMaxIter     = 2'd2;

  localparam logic [SizeW-1:0] FrameWidthRst  = 13'd640;
  localparam logic [SizeW-1:0] FrameHeightRst = 13'd480;
  localparam logic [IterW-1:0] MaxIterRst     = 8'd10;

  typedef struct packed {
    logic [SizeW-1:0] frame_width;
    logic [SizeW-1:0] frame_height;
    logic [IterW-1:0] limit;
  } cfg_t;

  typedef struct packed {
    logic load;       // take the pixel, start both divider lanes
    logic div_step;   // one quotient bit in each lane
    logic c_init;     // latch c, clear z and the count
    logic mul;        // register the three products
    logic upd;        // write back z, bump the count
    logic res_load;   // move the count into the result register
  } cmd_t;

  typedef struct packed {
    logic stop;       // escaped or limit reached, valid while products are current
  } sts_t;

  // Saturate a truncated quotient with its sign to Q4.28
  function automatic logic [QW-1:0] sat_coord(logic [DivW-1:0] q, logic neg);
    logic big;
    if (!neg) begin
      big = |q[DivW-1:QW-1];
      return big ? {1'b0, {(QW-1){1'b1}}} : q[QW-1:0];
    end
    big = (|q[DivW-1:QW]) || (q[QW-1] && (|q[QW-2:0]));
    return big ? {1'b1, {(QW-1){1'b0}}} : (~q[QW-1:0] + 1'b1);
  endfunction

  // Saturate a two's complement sum to Q4.28
  function automatic logic [QW-1:0] sat_sum(logic [SumW-1:0] v);
    if ((&v[SumW-1:QW-1]) || !(|v[SumW-1:QW-1])) begin
      return v[QW-1:0];
    end
    return v[SumW-1] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
  endfunction

endpackage

[hw/rtl/met_if.sv]
interface met_pix_if;
  logic                      valid;
  logic                      ready;
  logic [met_pkg::PixW-1:0]  pixel_col;
  logic [met_pkg::PixW-1:0]  pixel_row;

  modport source (output valid, output pixel_col, output pixel_row, input ready);
  modport sink   (input valid, input pixel_col, input pixel_row, output ready);
endinterface

interface met_res_if;
  logic                      valid;
  logic                      ready;
  logic [met_pkg::IterW-1:0] iter_count;
  logic                      inside_set;

  modport source (output valid, output iter_count, output inside_set, input ready);
  modport sink   (input valid, input iter_count, input inside_set, output ready);
endinterface

interface met_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [met_pkg::CfgIdxW-1:0]  index;
  logic [met_pkg::CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/met_div.sv]
module met_div (
  input  logic                       clk_i,
  input  logic                       load_i,
  input  logic                       step_i,
  input  logic [met_pkg::MagW-1:0]   dividend_i,
  input  logic [met_pkg::SizeW-1:0]  divisor_i,
  output logic [met_pkg::DivW-1:0]   quot_o
);

  localparam int unsigned SizeW = met_pkg::SizeW;
  localparam int unsigned DivW  = met_pkg::DivW;
  localparam int unsigned FracW = met_pkg::FracW;

  logic [DivW-1:0]  num_q, quot_q;
  logic [SizeW-1:0] rem_q, dvs_q, rem_d;
  logic [SizeW:0]   rem_sh, rem_sub;
  logic             ge;

  // Restoring division, one quotient bit a cycle while step_i is high, dividend shifted in MSB first
  assign rem_sh  = {rem_q, num_q[DivW-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_q};
  assign ge      = rem_sh >= {1'b0, dvs_q};
  assign rem_d   = ge ? rem_sub[SizeW-1:0] : rem_sh[SizeW-1:0];

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      num_q  <= {dividend_i, {FracW{1'b0}}};
      rem_q  <= '0;
      quot_q <= '0;
      dvs_q  <= divisor_i;
    end else if (step_i) begin
      num_q  <= {num_q[DivW-2:0], 1'b0};
      rem_q  <= rem_d;
      quot_q <= {quot_q[DivW-2:0], ge};
    end
  end

  assign quot_o = quot_q;

endmodule

[hw/rtl/met_datapath.sv]
module met_datapath (
  input  logic                      clk_i,
  input  met_pkg::cmd_t             cmd_i,
  input  met_pkg::cfg_t             cfg_i,
  input  logic [met_pkg::PixW-1:0]  pixel_col_i,
  input  logic [met_pkg::PixW-1:0]  pixel_row_i,
  output met_pkg::sts_t             sts_o,
  output logic [met_pkg::IterW-1:0] iter_count_o,
  output logic                      inside_set_o
);

  localparam int unsigned PixW  = met_pkg::PixW;
  localparam int unsigned SizeW = met_pkg::SizeW;
  localparam int unsigned IterW = met_pkg::IterW;
  localparam int unsigned QW    = met_pkg::QW;
  localparam int unsigned FracW = met_pkg::FracW;
  localparam int unsigned ProdW = met_pkg::ProdW;
  localparam int unsigned SumW  = met_pkg::SumW;
  localparam int unsigned MagW  = met_pkg::MagW;
  localparam int unsigned DivW  = met_pkg::DivW;

  localparam logic [ProdW:0] MagFour = (ProdW + 1)'(4) << (2 * FracW);

  logic [SizeW-1:0]        w_eff, h_eff;
  logic signed [PixW+1:0]  d_re, d_im;
  logic [PixW-1:0]         abs_re, abs_im;
  logic [MagW-1:0]         num_re, num_im;
  logic                    neg_re_q, neg_im_q;
  logic [DivW-1:0]         quot_re, quot_im;

  logic signed [QW-1:0]    cr_q, ci_q, zr_q, zi_q;
  logic signed [ProdW-1:0] rr_d, ii_d, ri_d, rr_q, ii_q, ri_q, diff;
  logic [SumW-1:0]         re_sum, im_sum;
  logic [ProdW:0]          mag;
  logic [IterW-1:0]        cnt_q, iter_q;
  logic                    inside_q, lim_hit;

  // Coordinate offsets from the frame center; an empty frame counts as one pixel
  assign w_eff  = (cfg_i.frame_width  == '0) ? SizeW'(1) : cfg_i.frame_width;
  assign h_eff  = (cfg_i.frame_height == '0) ? SizeW'(1) : cfg_i.frame_height;
  assign d_re   = $signed({2'b00, pixel_col_i}) - $signed({2'b00, w_eff[SizeW-1:1]});
  assign d_im   = $signed({2'b00, pixel_row_i}) - $signed({2'b00, h_eff[SizeW-1:1]});
  assign abs_re = d_re[PixW+1] ? PixW'(-d_re) : d_re[PixW-1:0];
  assign abs_im = d_im[PixW+1] ? PixW'(-d_im) : d_im[PixW-1:0];
  assign num_re = {1'b0, abs_re, 1'b0} + {2'b00, abs_re};   // times 3
  assign num_im = {1'b0, abs_im, 1'b0};                     // times 2

  met_div u_div_re (
    .clk_i,
    .load_i     (cmd_i.load),
    .step_i     (cmd_i.div_step),
    .dividend_i (num_re),
    .divisor_i  (w_eff),
    .quot_o     (quot_re)
  );

  met_div u_div_im (
    .clk_i,
    .load_i     (cmd_i.load),
    .step_i     (cmd_i.div_step),
    .dividend_i (num_im),
    .divisor_i  (h_eff),
    .quot_o     (quot_im)
  );

  // Complex square: three products, registered
  assign rr_d = zr_q * zr_q;
  assign ii_d = zi_q * zi_q;
  assign ri_d = zr_q * zi_q;

  assign mag  = {1'b0, rr_q} + {1'b0, ii_q};
  assign diff = rr_q - ii_q;

  // Floor shift by FracW is an arithmetic right shift; doubling folds into it
  assign re_sum = {{(SumW-(ProdW-FracW)){diff[ProdW-1]}}, diff[ProdW-1:FracW]}
                + {{(SumW-QW){cr_q[QW-1]}}, cr_q};
  assign im_sum = {{(SumW-(ProdW-FracW+1)){ri_q[ProdW-1]}}, ri_q[ProdW-1:FracW-1]}
                + {{(SumW-QW){ci_q[QW-1]}}, ci_q};

  assign lim_hit    = cnt_q >= cfg_i.limit;
  assign sts_o.stop = lim_hit || (mag > MagFour);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      neg_re_q <= d_re[PixW+1];
      neg_im_q <= d_im[PixW+1];
    end
    if (cmd_i.c_init) begin
      cr_q  <= met_pkg::sat_coord(quot_re, neg_re_q);
      ci_q  <= met_pkg::sat_coord(quot_im, neg_im_q);
      zr_q  <= '0;
      zi_q  <= '0;
      cnt_q <= '0;
    end else if (cmd_i.upd) begin
      zr_q  <= met_pkg::sat_sum(re_sum);
      zi_q  <= met_pkg::sat_sum(im_sum);
      cnt_q <= cnt_q + 1'b1;
    end
    if (cmd_i.mul) begin
      rr_q <= rr_d;
      ii_q <= ii_d;
      ri_q <= ri_d;
    end
    if (cmd_i.res_load) begin
      iter_q   <= cnt_q;
      inside_q <= lim_hit;
    end
  end

  assign iter_count_o = iter_q;
  assign inside_set_o = inside_q;

endmodule

[hw/rtl/met_ctrl.sv]
module met_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  met_pkg::sts_t sts_i,
  output met_pkg::cmd_t cmd_o
);

  localparam int unsigned DivW    = met_pkg::DivW;
  localparam int unsigned DivCntW = met_pkg::DivCntW;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StDiv   = 3'd1;
  localparam logic [2:0] StCinit = 3'd2;
  localparam logic [2:0] StMul   = 3'd3;
  localparam logic [2:0] StChk   = 3'd4;

  localparam logic [DivCntW-1:0] DivLast = DivCntW'(DivW - 1);

  logic [2:0]         state_q, state_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               ovalid_q, ovalid_d, out_free;

  assign out_free   = !ovalid_q || out_ready_i;
  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    cmd_o    = '0;
    ovalid_d = ovalid_q && !out_ready_i;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = StDiv;
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == DivLast) begin
          state_d = StCinit;
        end
      end
      StCinit: begin
        cmd_o.c_init = 1'b1;
        state_d      = StMul;
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        state_d   = StChk;
      end
      StChk: begin
        // On stop, hold with products intact until the result register frees up
        if (!sts_i.stop) begin
          cmd_o.upd = 1'b1;
          state_d   = StMul;
        end else if (out_free) begin
          cmd_o.res_load = 1'b1;
          ovalid_d       = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign out_valid_o = ovalid_q;

endmodule

[hw/rtl/mandelbrot_escape_time.sv]
// Channel   Dir  Payload                     Transaction
// pix_i     in   pixel_col, pixel_row        one pixel to evaluate
// res_o     out  iter_count, inside_set      one escape-time result per pixel
// cfg_i     in   index, data                 write of frame_width/frame_height/max_iter
//
// A pixel occupies the block through an accept step, the coordinate divider (one
// quotient bit a cycle), a step that seeds z, then a multiply and a check per
// iteration on the complex multiplier plus one final multiply and check.
// Reset (rst_ni low, asynchronous) drops any pixel in flight and restores the
// register defaults 640 x 480, limit 10; there is no clearing pass.
// A result waits in its output register; a new pixel is taken meanwhile and only its
// own finish stalls until res_o frees up. cfg_i is always ready.
module mandelbrot_escape_time #(
  parameter int unsigned MaxIterLimit = met_pkg::MaxIterLimitDef
) (
  input logic       clk_i,
  input logic       rst_ni,
  met_pix_if.sink   pix_i,
  met_res_if.source res_o,
  met_cfg_if.sink   cfg_i
);

  localparam int unsigned SizeW = met_pkg::SizeW;
  localparam int unsigned IterW = met_pkg::IterW;

  // Effective limit ceiling: the parameter clamped to what the count field holds
  localparam logic [IterW-1:0] LimitCap = (MaxIterLimit > met_pkg::IterMax)
                                        ? IterW'(met_pkg::IterMax)
                                        : IterW'(MaxIterLimit);

  logic [SizeW-1:0] frame_width_q, frame_height_q;
  logic [IterW-1:0] max_iter_q;
  logic             cfg_we;
  met_pkg::cfg_t    cfg;
  met_pkg::cmd_t    cmd;
  met_pkg::sts_t    sts;

  // Configuration registers: accept every write, ignore indexes past the list
  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid && cfg_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= met_pkg::FrameWidthRst;
      frame_height_q <= met_pkg::FrameHeightRst;
      max_iter_q     <= met_pkg::MaxIterRst;
    end else if (cfg_we) begin
      unique case (cfg_i.index)
        met_pkg::CfgFrameWidth:  frame_width_q  <= cfg_i.data[SizeW-1:0];
        met_pkg::CfgFrameHeight: frame_height_q <= cfg_i.data[SizeW-1:0];
        met_pkg::CfgMaxIter:     max_iter_q     <= cfg_i.data[IterW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.frame_width  = frame_width_q;
  assign cfg.frame_height = frame_height_q;
  assign cfg.limit        = (max_iter_q > LimitCap) ? LimitCap : max_iter_q;

  // Sequencer: accept, divide, seed, then multiply/check until escape or limit
  met_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i  (pix_i.valid),
    .in_ready_o  (pix_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Coordinate mapping, z = z^2 + c datapath and the result register
  met_datapath u_datapath (
    .clk_i,
    .cmd_i        (cmd),
    .cfg_i        (cfg),
    .pixel_col_i  (pix_i.pixel_col),
    .pixel_row_i  (pix_i.pixel_row),
    .sts_o        (sts),
    .iter_count_o (res_o.iter_count),
    .inside_set_o (res_o.inside_set)
  );

  // The sequencer drives at most one datapath command per cycle
  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.div_step, cmd.c_init, cmd.mul, cmd.upd, cmd.res_load}))
    else $error("more than one datapath command active");

  // A pixel transaction occupies the block; no second one on the next edge
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_i.valid && pix_i.ready) |=> !pix_i.ready)
    else $error("pixel accepted right after another");

  // The delivered count never passes the limit ceiling
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.iter_count <= LimitCap))
    else $error("iteration count beyond limit");

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned PixW     = met_pkg::PixW;
  localparam int unsigned SizeW    = met_pkg::SizeW;
  localparam int unsigned IterW    = met_pkg::IterW;
  localparam int unsigned FracW    = met_pkg::FracW;
  localparam int unsigned CfgDataW = met_pkg::CfgDataW;

  localparam int unsigned ITER_CAP = met_pkg::MaxIterLimitDef;
  // Escape radius squared, 4.0 in the unsigned Q8.56 magnitude format.
  localparam logic [63:0] ESCAPE_MAG = 64'd4 << (2 * FracW);
  localparam longint Q_HI = 64'sd2147483647;
  localparam longint Q_LO = -64'sd2147483648;
  // Settle time before the verdict, longer than the longest pixel takes.
  localparam int unsigned SETTLE_CYCLES = 600;

  typedef struct {
    logic [IterW-1:0] iter_count;
    logic             inside_set;
  } escape_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  met_pix_if pix_bus ();
  met_res_if res_bus ();
  met_cfg_if cfg_bus ();

  mandelbrot_escape_time #(
    .MaxIterLimit(ITER_CAP)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .pix_i (pix_bus),
    .res_o (res_bus),
    .cfg_i (cfg_bus)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the frame registers, updated on each accepted write transaction.
  logic [SizeW-1:0] frame_w;
  logic [SizeW-1:0] frame_h;
  logic [IterW-1:0] iter_lim;

  // Escape results still owed by the block, oldest first.
  escape_t escape_q[$];

  int unsigned fail_count;
  int unsigned pixels_sent;
  int unsigned results_seen;
  int unsigned inside_seen;
  int unsigned settings_used;
  bit          quiet_phase;
  int unsigned ready_hold = 0;

  // ---------------------------------------------------------------------------
  // Escape-time predictor
  // ---------------------------------------------------------------------------

  // Clamp a wide value to the signed Q4.28 range.
  function automatic longint sat_q428(longint v);
    if (v > Q_HI) return Q_HI;
    if (v < Q_LO) return Q_LO;
    return v;
  endfunction

  // scale * (pos - floor(size/2)) / size as Q4.28, truncated toward zero.
  // A zero frame size counts as one pixel.
  function automatic longint pixel_to_q428(logic [PixW-1:0] pos, logic [SizeW-1:0] size,
                                           longint scale);
    longint span;
    longint offs;
    longint quo;
    logic   neg;
    span = (size == '0) ? 64'sd1 : longint'(size);
    offs = longint'(pos) - span / 2;
    neg  = offs < 0;
    quo  = (((neg ? -offs : offs) * scale) << FracW) / span;
    return sat_q428(neg ? -quo : quo);
  endfunction

  function automatic escape_t predict_escape(logic [PixW-1:0] col, logic [PixW-1:0] row);
    escape_t     res;
    longint      c_re;
    longint      c_im;
    longint      z_re;
    longint      z_im;
    longint      re_sq;
    longint      im_sq;
    logic [63:0] mag;
    int unsigned cap;
    int unsigned n;
    cap = 32'(iter_lim);
    if (cap > ITER_CAP) cap = ITER_CAP;
    c_re = pixel_to_q428(col, frame_w, 3);
    c_im = pixel_to_q428(row, frame_h, 2);
    z_re = 0;
    z_im = 0;
    n    = 0;
    while (1'b1) begin
      re_sq = z_re * z_re;
      im_sq = z_im * z_im;
      mag   = $unsigned(re_sq) + $unsigned(im_sq);
      if (mag > ESCAPE_MAG || n >= cap) break;
      // Drop back to Q4.28 with floor rounding, add c, then saturate.
      z_im = sat_q428(((2 * (z_re * z_im)) >>> FracW) + c_im);
      z_re = sat_q428(((re_sq - im_sq) >>> FracW) + c_re);
      n++;
    end
    res.iter_count = n[IterW-1:0];
    res.inside_set = (n >= cap);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random backpressure and the scoreboard
  // ---------------------------------------------------------------------------

  // Hold ready low in bursts of random length; none during the quiet phase.
  always @(posedge clk_i) begin
    if (quiet_phase) begin
      res_bus.ready <= 1'b1;
    end else if (ready_hold != 0) begin
      res_bus.ready <= 1'b0;
      ready_hold    = ready_hold - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      res_bus.ready <= 1'b0;
      ready_hold    = $urandom_range(0, 9);
    end else begin
      res_bus.ready <= 1'b1;
    end
  end

  // Compare each result transaction with the oldest expectation.
  always @(posedge clk_i) begin
    escape_t want;
    if (rst_ni === 1'b1 && res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
      results_seen++;
      if (escape_q.size() == 0) begin
        $error("unexpected result: iter_count %0d inside_set %0b",
               res_bus.iter_count, res_bus.inside_set);
        fail_count++;
      end else begin
        want = escape_q.pop_front();
        if (want.inside_set) inside_seen++;
        if (res_bus.iter_count !== want.iter_count) begin
          $error("iter_count: expected %0d, got %0d", want.iter_count, res_bus.iter_count);
          fail_count++;
        end
        if (res_bus.inside_set !== want.inside_set) begin
          $error("inside_set: expected %0b, got %0b", want.inside_set, res_bus.inside_set);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Offer one pixel, with an occasional idle burst ahead of it. Valid stays high
  // after the transaction so that back-to-back pixels need no gap.
  task automatic send_pixel(input logic [PixW-1:0] col, input logic [PixW-1:0] row);
    int unsigned gap;
    if (!quiet_phase && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 10);
      pix_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix_bus.valid     <= 1'b1;
    pix_bus.pixel_col <= col;
    pix_bus.pixel_row <= row;
    @(posedge clk_i);
    while (pix_bus.ready !== 1'b1) @(posedge clk_i);
    escape_q.push_back(predict_escape(col, row));
    pixels_sent++;
  endtask

  // Drop valid and hold off until every owed result has come back.
  task automatic drain_results();
    pix_bus.valid <= 1'b0;
    while (escape_q.size() != 0) @(posedge clk_i);
  endtask

  // Write all three registers back to back while the block is idle. The spare
  // upper data bits of the limit write must be ignored by the block.
  task automatic set_config(input logic [SizeW-1:0] w, input logic [SizeW-1:0] h,
                            input logic [IterW-1:0] lim, input logic [CfgDataW-IterW-1:0] pad);
    drain_results();
    for (int k = 0; k < 3; k++) begin
      cfg_bus.valid <= 1'b1;
      case (k)
        0: begin
          cfg_bus.index <= met_pkg::CfgFrameWidth;
          cfg_bus.data  <= w;
        end
        1: begin
          cfg_bus.index <= met_pkg::CfgFrameHeight;
          cfg_bus.data  <= h;
        end
        default: begin
          cfg_bus.index <= met_pkg::CfgMaxIter;
          cfg_bus.data  <= {pad, lim};
        end
      endcase
      @(posedge clk_i);
      while (cfg_bus.ready !== 1'b1) @(posedge clk_i);
      case (k)
        0:       frame_w  = w;
        1:       frame_h  = h;
        default: iter_lim = lim;
      endcase
    end
    cfg_bus.valid <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [SizeW-1:0] pick_size();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 13'd1;
      2:       return 13'd4096;
      3:       return 13'd8191;
      4, 5:    return SizeW'($urandom_range(1, 16));
      6:       return SizeW'($urandom_range(0, 8191));
      default: return SizeW'($urandom_range(1, 4096));
    endcase
  endfunction

  function automatic logic [IterW-1:0] pick_limit();
    case ($urandom_range(0, 19))
      0:       return '0;
      1, 2:    return 8'd255;
      3:       return IterW'($urandom_range(100, 254));
      default: return IterW'($urandom_range(1, 40));
    endcase
  endfunction

  // Mostly a pixel inside the frame, sometimes any 12-bit coordinate.
  function automatic logic [PixW-1:0] pick_pos(logic [SizeW-1:0] size);
    int unsigned top;
    if ($urandom_range(0, 3) == 0) return PixW'($urandom_range(0, 4095));
    top = (size == '0) ? 0 : ((size > 4096) ? 4095 : 32'(size) - 1);
    return PixW'($urandom_range(0, top));
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values: 640 x 480 frame, limit 10, no register written yet.
  task automatic test_reset_defaults();
    frame_w  = met_pkg::FrameWidthRst;
    frame_h  = met_pkg::FrameHeightRst;
    iter_lim = met_pkg::MaxIterRst;
    send_pixel(12'd320, 12'd240);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd639, 12'd479);
  endtask

  // Smallest, zero and largest frames, zero and full limits, pixels far outside.
  task automatic test_frame_extremes();
    set_config(13'd1, 13'd1, 8'd1, '0);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    set_config('0, '0, '0, '1);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd0);
    set_config(13'd8191, 13'd8191, 8'd255, '0);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd4095, 12'd0);
    set_config(13'd4096, 13'd4096, 8'd255, '0);
    send_pixel(12'd2048, 12'd2048);   // origin, runs to the limit
    send_pixel(12'd1024, 12'd2048);   // cardioid/bulb neck on the real axis
    send_pixel(12'd0, 12'd2048);      // deep on the negative real axis
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd3072, 12'd1024);
    set_config(13'd2, 13'd3, 8'd255, '0);
    send_pixel(12'd4095, 12'd4095);   // c saturates on both axes
    send_pixel(12'd1, 12'd1);
    send_pixel(12'd4095, 12'd0);
  endtask

  // Random settings; each change drains the pipe first, so the sender pauses
  // with everything owed already returned.
  task automatic test_random_settings();
    int unsigned n;
    for (int phase = 0; phase < 18; phase++) begin
      set_config(pick_size(), pick_size(), pick_limit(), ($urandom_range(0, 1) == 0) ? '0 :
                 (CfgDataW-IterW)'($urandom_range(0, 31)));
      n = $urandom_range(40, 60);
      repeat (n) send_pixel(pick_pos(frame_w), pick_pos(frame_h));
    end
  endtask

  // Full-rate stream with no idling on either side.
  task automatic test_steady_stream();
    set_config(13'd640, 13'd480, IterW'($urandom_range(8, 48)), '0);
    quiet_phase = 1'b1;
    repeat (150) send_pixel(pick_pos(frame_w), pick_pos(frame_h));
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    fail_count    = 0;
    pixels_sent   = 0;
    results_seen  = 0;
    inside_seen   = 0;
    settings_used = 0;
    quiet_phase   = 1'b0;
    rst_ni            <= 1'b0;
    pix_bus.valid     <= 1'b0;
    pix_bus.pixel_col <= '0;
    pix_bus.pixel_row <= '0;
    cfg_bus.valid     <= 1'b0;
    cfg_bus.index     <= met_pkg::CfgFrameWidth;
    cfg_bus.data      <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_frame_extremes();
    test_random_settings();
    test_steady_stream();

    // Wait out the tail, then give any stray result time to show up.
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Sent %0d pixels under %0d register settings; %0d results, %0d inside the set.",
             pixels_sent, settings_used, results_seen, inside_seen);
    if (escape_q.size() != 0) begin
      $error("%0d results never arrived", escape_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("[mandelbrot_escape_time] OK");
    end else begin
      $display("[mandelbrot_escape_time] ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #40_000_000;
    $display("[mandelbrot_escape_time] ERROR");
    $finish;
  end

endmodule
